// ===== hdl/gbe_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Grid elevation package
// Shared constants, codes and types of the bilinear elevation grid.
// ----------------------------------------------------------------------------
package gbe_pkg;

  localparam int MAX_COLUMNS_DEF = 256;
  localparam int MAX_ROWS_DEF    = 256;
  localparam int SAMPLE_BITS_DEF = 32;

  // -9999.0 in Q16.16
  localparam logic signed [31:0] OUTSIDE_VALUE = -32'sd655294464;
  localparam logic [16:0]        ONE_Q16       = 17'h10000;
  localparam logic [15:0]        HALF_Q16      = 16'h8000;

  typedef enum logic {
    OP_WRITE = 1'b0,
    OP_QUERY = 1'b1
  } op_t;

  typedef enum logic [2:0] {
    CFG_ORIGIN_EAST    = 3'd0,
    CFG_ORIGIN_NORTH   = 3'd1,
    CFG_INV_CELL_EAST  = 3'd2,
    CFG_INV_CELL_NORTH = 3'd3,
    CFG_COLUMNS        = 3'd4,
    CFG_ROWS           = 3'd5
  } cfg_reg_t;

  typedef struct packed {
    logic signed [31:0] origin_east;
    logic signed [31:0] origin_north;
    logic [31:0]        inv_cell_east;
    logic [31:0]        inv_cell_north;
  } gbe_geom_t;

endpackage

// ===== hdl/gbe_in_if.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Grid elevation input channel
// Valid/ready channel carrying one write or query item.
// ----------------------------------------------------------------------------
interface gbe_in_if;
  logic               valid;
  logic               ready;
  logic               op;
  logic [7:0]         column;
  logic [7:0]         row;
  logic signed [31:0] sample;
  logic signed [31:0] east;
  logic signed [31:0] north;

  modport source(output valid, op, column, row, sample, east, north, input ready);
  modport sink(input valid, op, column, row, sample, east, north, output ready);
endinterface

// ===== hdl/gbe_out_if.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Grid elevation result channel
// Valid/ready channel carrying one elevation result item.
// ----------------------------------------------------------------------------
interface gbe_out_if;
  logic               valid;
  logic               ready;
  logic signed [31:0] elevation;
  logic               outside;

  modport source(output valid, elevation, outside, input ready);
  modport sink(input valid, elevation, outside, output ready);
endinterface

// ===== hdl/gbe_cfg_if.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Grid elevation configuration channel
// Valid/ready register write channel: register index and write data.
// ----------------------------------------------------------------------------
interface gbe_cfg_if;
  logic        valid;
  logic        ready;
  logic [2:0]  index;
  logic [31:0] data;

  modport source(output valid, index, data, input ready);
  modport sink(input valid, index, data, output ready);
endinterface

// ===== hdl/gbe_ram.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Generic RAM
// One write port, one read port with registered read data.
// ----------------------------------------------------------------------------
module gbe_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 256,
  localparam int AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic             re,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata_r <= mem[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

// ===== hdl/gbe_cfg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Grid elevation configuration registers
// Holds origin, reciprocal spacing and grid size; derives last cell indexes.
// ----------------------------------------------------------------------------
module gbe_cfg #(
  parameter int MAX_COLUMNS = gbe_pkg::MAX_COLUMNS_DEF,
  parameter int MAX_ROWS    = gbe_pkg::MAX_ROWS_DEF,
  localparam int CIW        = $clog2(MAX_COLUMNS),
  localparam int RIW        = $clog2(MAX_ROWS)
) (
  input  logic              clk,
  input  logic              rst_n,
  gbe_cfg_if.sink           cfg_ch,
  output gbe_pkg::gbe_geom_t geom,
  output logic [CIW-1:0]    last_col,
  output logic [RIW-1:0]    last_row
);

  gbe_pkg::gbe_geom_t geom_r;
  logic [8:0]         columns_r;
  logic [8:0]         rows_r;

  assign cfg_ch.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      geom_r.origin_east    <= '0;
      geom_r.origin_north   <= '0;
      geom_r.inv_cell_east  <= 32'd65536;
      geom_r.inv_cell_north <= 32'd65536;
      columns_r             <= 9'd256;
      rows_r                <= 9'd256;
    end else if (cfg_ch.valid && cfg_ch.ready) begin
      case (gbe_pkg::cfg_reg_t'(cfg_ch.index))
        gbe_pkg::CFG_ORIGIN_EAST:    geom_r.origin_east    <= $signed(cfg_ch.data);
        gbe_pkg::CFG_ORIGIN_NORTH:   geom_r.origin_north   <= $signed(cfg_ch.data);
        gbe_pkg::CFG_INV_CELL_EAST:  geom_r.inv_cell_east  <= cfg_ch.data;
        gbe_pkg::CFG_INV_CELL_NORTH: geom_r.inv_cell_north <= cfg_ch.data;
        gbe_pkg::CFG_COLUMNS:        columns_r             <= cfg_ch.data[8:0];
        gbe_pkg::CFG_ROWS:           rows_r                <= cfg_ch.data[8:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    if (columns_r == 9'd0) begin
      last_col = '0;
    end else if (32'(columns_r) > 32'(MAX_COLUMNS)) begin
      last_col = CIW'(MAX_COLUMNS - 1);
    end else begin
      last_col = CIW'(columns_r - 9'd1);
    end
    if (rows_r == 9'd0) begin
      last_row = '0;
    end else if (32'(rows_r) > 32'(MAX_ROWS)) begin
      last_row = RIW'(MAX_ROWS - 1);
    end else begin
      last_row = RIW'(rows_r - 9'd1);
    end
  end

  assign geom = geom_r;

endmodule

// ===== hdl/gbe_locate.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Grid elevation axis locator
// Three stages: offset from origin, scale by reciprocal spacing, range check
// and split into cell index and Q0.16 fraction.
// ----------------------------------------------------------------------------
module gbe_locate #(
  parameter int MAX_COUNT = 256,
  localparam int IW       = $clog2(MAX_COUNT)
) (
  input  logic               clk,
  input  logic               en,
  input  logic signed [31:0] coord,
  input  logic signed [31:0] origin,
  input  logic [31:0]        inv,
  input  logic [IW-1:0]      last_idx,
  output logic [IW-1:0]      idx,
  output logic [15:0]        frac,
  output logic               outside,
  output logic               has_next
);

  logic signed [32:0] diff;
  logic [31:0]        d_r;
  logic               neg_a_r;
  logic [63:0]        p_r;
  logic               neg_b_r;
  logic [31:0]        hi;
  logic [31:0]        lim;
  logic               over;
  logic [IW-1:0]      idx_r;
  logic [15:0]        frac_r;
  logic               out_r;
  logic               next_r;

  assign diff = 33'(coord) - 33'(origin);
  assign hi   = p_r[63:32];
  assign lim  = 32'(last_idx);
  assign over = (hi > lim) || ((hi == lim) && (p_r[31:0] != 32'd0));

  always_ff @(posedge clk) begin
    if (en) begin
      d_r     <= diff[31:0];
      neg_a_r <= diff[32];
      p_r     <= 64'(d_r) * 64'(inv);
      neg_b_r <= neg_a_r;
      idx_r   <= p_r[32 +: IW];
      frac_r  <= p_r[31:16];
      out_r   <= neg_b_r || over;
      next_r  <= hi < lim;
    end
  end

  assign idx      = idx_r;
  assign frac     = frac_r;
  assign outside  = out_r;
  assign has_next = next_r;

endmodule

// ===== hdl/gbe_blend.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Grid elevation linear blend
// a*(1-f) + b*f with Q0.16 weight, rounded half up; products then sum.
// ----------------------------------------------------------------------------
module gbe_blend (
  input  logic               clk,
  input  logic               en,
  input  logic signed [31:0] a,
  input  logic signed [31:0] b,
  input  logic [15:0]        f,
  output logic signed [31:0] y
);

  logic [16:0]        w;
  logic signed [49:0] pa_r;
  logic signed [48:0] pb_r;
  logic signed [50:0] sum;
  logic signed [31:0] y_r;

  assign w   = gbe_pkg::ONE_Q16 - {1'b0, f};
  assign sum = 51'(pa_r) + 51'(pb_r) + $signed(51'(gbe_pkg::HALF_Q16));

  always_ff @(posedge clk) begin
    if (en) begin
      pa_r <= 50'(a) * 50'($signed({1'b0, w}));
      pb_r <= 49'(b) * 49'($signed({1'b0, f}));
      y_r  <= sum[47:16];
    end
  end

  assign y = y_r;

endmodule

// ===== hdl/grid_bilinear_elevation_top.sv =====
`timescale 1ns / 1ps
// Throughput: one item per cycle unless a stalled result holds the pipeline; a
// write item lands in the grid RAM ahead of any later query's RAM read.
// A stalled result holds the whole pipeline until it is taken.
// Reset clears pipeline valid bits and configuration; grid contents stay
// undefined until written.
// ----------------------------------------------------------------------------
// Grid bilinear elevation top level
// Axis locators feed four grid RAM banks split by row and column parity, so
// all four corners of a cell are read in the same cycle; three blend units combine them.
// ----------------------------------------------------------------------------
module grid_bilinear_elevation_top #(
  parameter int MAX_COLUMNS = gbe_pkg::MAX_COLUMNS_DEF,
  parameter int MAX_ROWS    = gbe_pkg::MAX_ROWS_DEF,
  parameter int SAMPLE_BITS = gbe_pkg::SAMPLE_BITS_DEF
) (
  input  logic      clk,
  input  logic      rst_n,
  gbe_in_if.sink    in_ch,
  gbe_out_if.source out_ch,
  gbe_cfg_if.sink   cfg_ch
);

  localparam int CIW   = $clog2(MAX_COLUMNS);
  localparam int RIW   = $clog2(MAX_ROWS);
  localparam int HCW   = (CIW > 1) ? CIW - 1 : 1;
  localparam int HRW   = (RIW > 1) ? RIW - 1 : 1;
  localparam int AW    = HRW + HCW;
  localparam int DEPTH = 2 ** AW;

  typedef struct packed {
    logic                   wok;
    logic [7:0]             column;
    logic [7:0]             row;
    logic [SAMPLE_BITS-1:0] sample;
  } wr_t;

  typedef struct packed {
    logic [15:0] fx;
    logic [15:0] fy;
    logic        ip;
    logic        jp;
    logic        has_r;
    logic        has_u;
    logic        outside;
  } rd_flags_t;

  typedef struct packed {
    logic [15:0] fy;
    logic        has_u;
    logic        outside;
  } row_flags_t;

  gbe_pkg::gbe_geom_t geom;
  logic [CIW-1:0]     last_col;
  logic [RIW-1:0]     last_row;

  logic               adv;
  logic [6:0]         vq_r;
  logic [2:0]         vw_r;
  logic               out_valid_r;
  logic               out_out_r;
  wr_t                wr_nxt;
  wr_t                wr_r [3];

  logic [CIW-1:0]     i3;
  logic [RIW-1:0]     j3;
  logic [15:0]        fx3;
  logic [15:0]        fy3;
  logic               out_e3;
  logic               out_n3;
  logic               next_e3;
  logic               next_n3;

  logic [CIW:0]       i_ext;
  logic [CIW:0]       i_inc;
  logic [RIW:0]       j_ext;
  logic [RIW:0]       j_inc;
  logic [HCW-1:0]     i_odd;
  logic [HCW-1:0]     i_even;
  logic [HRW-1:0]     j_odd;
  logic [HRW-1:0]     j_even;
  logic [HCW-1:0]     wch;
  logic [HRW-1:0]     wrh;

  logic [SAMPLE_BITS-1:0] rd [4];
  logic signed [31:0]     rd_ext [4];
  logic signed [31:0]     z00;
  logic signed [31:0]     z01;
  logic signed [31:0]     z10;
  logic signed [31:0]     z11;
  logic signed [31:0]     r0;
  logic signed [31:0]     r1;
  logic signed [31:0]     r1_sel;
  logic signed [31:0]     y;

  rd_flags_t  s4_r;
  row_flags_t s5_r;
  row_flags_t s6_r;
  logic       s7_out_r;

  gbe_cfg #(
    .MAX_COLUMNS(MAX_COLUMNS),
    .MAX_ROWS   (MAX_ROWS)
  ) u_cfg (
    .clk     (clk),
    .rst_n   (rst_n),
    .cfg_ch  (cfg_ch),
    .geom    (geom),
    .last_col(last_col),
    .last_row(last_row)
  );

  assign adv         = !out_valid_r || out_ch.ready;
  assign in_ch.ready = adv;

  assign wr_nxt.wok    = (32'(in_ch.column) < 32'(MAX_COLUMNS)) &&
                         (32'(in_ch.row) < 32'(MAX_ROWS));
  assign wr_nxt.column = in_ch.column;
  assign wr_nxt.row    = in_ch.row;
  assign wr_nxt.sample = SAMPLE_BITS'(in_ch.sample);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vq_r        <= '0;
      vw_r        <= '0;
      out_valid_r <= 1'b0;
    end else if (adv) begin
      vq_r        <= {vq_r[5:0], in_ch.valid && (in_ch.op == gbe_pkg::OP_QUERY)};
      vw_r        <= {vw_r[1:0], in_ch.valid && (in_ch.op == gbe_pkg::OP_WRITE)};
      out_valid_r <= vq_r[6];
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      wr_r[0] <= wr_nxt;
      wr_r[1] <= wr_r[0];
      wr_r[2] <= wr_r[1];
    end
  end

  gbe_locate #(.MAX_COUNT(MAX_COLUMNS)) u_loc_east (
    .clk     (clk),
    .en      (adv),
    .coord   (in_ch.east),
    .origin  (geom.origin_east),
    .inv     (geom.inv_cell_east),
    .last_idx(last_col),
    .idx     (i3),
    .frac    (fx3),
    .outside (out_e3),
    .has_next(next_e3)
  );

  gbe_locate #(.MAX_COUNT(MAX_ROWS)) u_loc_north (
    .clk     (clk),
    .en      (adv),
    .coord   (in_ch.north),
    .origin  (geom.origin_north),
    .inv     (geom.inv_cell_north),
    .last_idx(last_row),
    .idx     (j3),
    .frac    (fy3),
    .outside (out_n3),
    .has_next(next_n3)
  );

  // even bank holds whichever of idx, idx+1 is even; odd bank the other
  assign i_ext  = {1'b0, i3};
  assign i_inc  = i_ext + (CIW + 1)'(1);
  assign j_ext  = {1'b0, j3};
  assign j_inc  = j_ext + (RIW + 1)'(1);
  assign i_odd  = HCW'(i_ext >> 1);
  assign i_even = HCW'(i_inc >> 1);
  assign j_odd  = HRW'(j_ext >> 1);
  assign j_even = HRW'(j_inc >> 1);
  assign wch    = HCW'(wr_r[2].column >> 1);
  assign wrh    = HRW'(wr_r[2].row >> 1);

  for (genvar b = 0; b < 4; b++) begin : g_bank
    localparam logic RP = 1'(b / 2);
    localparam logic CP = 1'(b % 2);
    logic          we;
    logic [AW-1:0] raddr;

    assign we    = adv && vw_r[2] && wr_r[2].wok &&
                   (wr_r[2].row[0] == RP) && (wr_r[2].column[0] == CP);
    assign raddr = {(RP ? j_odd : j_even), (CP ? i_odd : i_even)};

    gbe_ram #(
      .WIDTH(SAMPLE_BITS),
      .DEPTH(DEPTH)
    ) u_ram (
      .clk  (clk),
      .we   (we),
      .waddr({wrh, wch}),
      .wdata(wr_r[2].sample),
      .re   (adv),
      .raddr(raddr),
      .rdata(rd[b])
    );

    assign rd_ext[b] = 32'($signed(rd[b]));
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      s4_r.fx      <= fx3;
      s4_r.fy      <= fy3;
      s4_r.ip      <= i3[0];
      s4_r.jp      <= j3[0];
      s4_r.has_r   <= next_e3;
      s4_r.has_u   <= next_n3;
      s4_r.outside <= out_e3 || out_n3;
      s5_r.fy      <= s4_r.fy;
      s5_r.has_u   <= s4_r.has_u;
      s5_r.outside <= s4_r.outside;
      s6_r         <= s5_r;
      s7_out_r     <= s6_r.outside;
      out_out_r    <= s7_out_r;
    end
  end

  assign z00 = rd_ext[{s4_r.jp, s4_r.ip}];
  assign z01 = s4_r.has_r ? rd_ext[{s4_r.jp, !s4_r.ip}] : '0;
  assign z10 = rd_ext[{!s4_r.jp, s4_r.ip}];
  assign z11 = s4_r.has_r ? rd_ext[{!s4_r.jp, !s4_r.ip}] : '0;

  gbe_blend u_blend_row0 (
    .clk(clk),
    .en (adv),
    .a  (z00),
    .b  (z01),
    .f  (s4_r.fx),
    .y  (r0)
  );

  gbe_blend u_blend_row1 (
    .clk(clk),
    .en (adv),
    .a  (z10),
    .b  (z11),
    .f  (s4_r.fx),
    .y  (r1)
  );

  assign r1_sel = s6_r.has_u ? r1 : '0;

  gbe_blend u_blend_col (
    .clk(clk),
    .en (adv),
    .a  (r0),
    .b  (r1_sel),
    .f  (s6_r.fy),
    .y  (y)
  );

  assign out_ch.valid     = out_valid_r;
  assign out_ch.outside   = out_out_r;
  assign out_ch.elevation = out_out_r ? gbe_pkg::OUTSIDE_VALUE : y;

endmodule

// ===== sim/tb_grid_bilinear_elevation_top.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Grid bilinear elevation testbench
// Loads grid samples, then drives write and query items through the valid/ready
// channels, with the sender pausing and the receiver stalling at random. Every
// query result is compared field by field against a fixed expected value or an
// in-bench model of the grid, the axis mapping and the bilinear blend. Runs
// several geometry settings, including the count, origin and spacing extremes.
// ----------------------------------------------------------------------------
module tb_grid_bilinear_elevation_top;

  localparam logic [2:0] CFG_SPARE = 3'd7;

  typedef struct {
    gbe_pkg::op_t       op;
    logic [7:0]         column;
    logic [7:0]         row;
    logic signed [31:0] sample;
    logic signed [31:0] east;
    logic signed [31:0] north;
    bit                 typed;
    logic signed [31:0] want_elev;
    logic               want_out;
  } grid_item_t;

  typedef struct {
    logic signed [31:0] elev;
    logic               outside;
  } elev_answer_t;

  typedef struct {
    logic [31:0] org_e;
    logic [31:0] org_n;
    logic [31:0] inv_e;
    logic [31:0] inv_n;
    logic [8:0]  cols;
    logic [8:0]  rows;
  } grid_setup_t;

  logic clk = 1'b0;
  logic rst_n;

  gbe_in_if  in_ch ();
  gbe_out_if out_ch ();
  gbe_cfg_if cfg_ch ();

  grid_bilinear_elevation_top u_top (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch),
    .out_ch (out_ch),
    .cfg_ch (cfg_ch)
  );

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  logic signed [31:0] grid_mem [0:65535];
  bit                 grid_set [0:65535];
  logic signed [31:0] geo_origin_e = '0;
  logic signed [31:0] geo_origin_n = '0;
  logic [31:0]        geo_inv_e    = 32'h0001_0000;
  logic [31:0]        geo_inv_n    = 32'h0001_0000;
  logic [8:0]         geo_cols     = 9'd256;
  logic [8:0]         geo_rows     = 9'd256;

  elev_answer_t pending_elevs [$];
  int           err_count  = 0;
  int           burst_left = 0;

  grid_item_t opening_rows [22] = '{
    '{gbe_pkg::OP_WRITE, 8'd0,   8'd0,   32'h7FFF_FFFF, 32'h0, 32'h0, 1'b0, 32'h0, 1'b0},
    '{gbe_pkg::OP_WRITE, 8'd1,   8'd0,   32'h8000_0000, 32'h0, 32'h0, 1'b0, 32'h0, 1'b0},
    '{gbe_pkg::OP_WRITE, 8'd0,   8'd1,   32'h0001_0000, 32'h0, 32'h0, 1'b0, 32'h0, 1'b0},
    '{gbe_pkg::OP_WRITE, 8'd1,   8'd1,   32'hFFFF_0000, 32'h0, 32'h0, 1'b0, 32'h0, 1'b0},
    '{gbe_pkg::OP_WRITE, 8'd255, 8'd255, 32'h1234_5678, 32'h0, 32'h0, 1'b0, 32'h0, 1'b0},
    '{gbe_pkg::OP_WRITE, 8'd254, 8'd255, 32'h0002_0000, 32'h0, 32'h0, 1'b0, 32'h0, 1'b0},
    '{gbe_pkg::OP_WRITE, 8'd255, 8'd254, 32'h0003_0000, 32'h0, 32'h0, 1'b0, 32'h0, 1'b0},
    '{gbe_pkg::OP_WRITE, 8'd254, 8'd254, 32'h0004_0000, 32'h0, 32'h0, 1'b0, 32'h0, 1'b0},
    '{gbe_pkg::OP_QUERY, 8'd0, 8'd0, 32'h0, 32'h0000_0000, 32'h0000_0000,
      1'b1, 32'h7FFF_FFFF, 1'b0},
    '{gbe_pkg::OP_QUERY, 8'd0, 8'd0, 32'h0, 32'h00FF_0000, 32'h00FF_0000,
      1'b1, 32'h1234_5678, 1'b0},
    '{gbe_pkg::OP_QUERY, 8'd0, 8'd0, 32'h0, 32'hFFFF_FFFF, 32'h0000_0000,
      1'b1, gbe_pkg::OUTSIDE_VALUE, 1'b1},
    '{gbe_pkg::OP_QUERY, 8'd0, 8'd0, 32'h0, 32'h0000_0000, 32'h8000_0000,
      1'b1, gbe_pkg::OUTSIDE_VALUE, 1'b1},
    '{gbe_pkg::OP_QUERY, 8'd0, 8'd0, 32'h0, 32'h00FF_0001, 32'h0000_0000,
      1'b1, gbe_pkg::OUTSIDE_VALUE, 1'b1},
    '{gbe_pkg::OP_QUERY, 8'd0, 8'd0, 32'h0, 32'h7FFF_FFFF, 32'h7FFF_FFFF,
      1'b1, gbe_pkg::OUTSIDE_VALUE, 1'b1},
    '{gbe_pkg::OP_QUERY, 8'd0, 8'd0, 32'h0, 32'h0000_8000, 32'h0000_8000,
      1'b0, 32'h0, 1'b0},
    '{gbe_pkg::OP_QUERY, 8'd0, 8'd0, 32'h0, 32'h0000_FFFF, 32'h0000_0000,
      1'b0, 32'h0, 1'b0},
    '{gbe_pkg::OP_QUERY, 8'd0, 8'd0, 32'h0, 32'h00FE_8000, 32'h00FF_0000,
      1'b0, 32'h0, 1'b0},
    '{gbe_pkg::OP_QUERY, 8'd0, 8'd0, 32'h0, 32'h00FF_0000, 32'h00FE_8000,
      1'b0, 32'h0, 1'b0},
    '{gbe_pkg::OP_QUERY, 8'd255, 8'd255, 32'hDEAD_BEEF, 32'h0000_0000, 32'h0000_0000,
      1'b1, 32'h7FFF_FFFF, 1'b0},
    '{gbe_pkg::OP_WRITE, 8'd0, 8'd0, 32'hFFFF_FFFF, 32'h7FFF_FFFF, 32'h8000_0000,
      1'b0, 32'h0, 1'b0},
    '{gbe_pkg::OP_QUERY, 8'd0, 8'd0, 32'h0, 32'h0000_0000, 32'h0000_0000,
      1'b1, 32'hFFFF_FFFF, 1'b0},
    '{gbe_pkg::OP_QUERY, 8'd0, 8'd0, 32'h0, 32'h8000_0000, 32'h00FF_0000,
      1'b1, gbe_pkg::OUTSIDE_VALUE, 1'b1}
  };

  function automatic int unsigned live_count(input logic [8:0] c, input int unsigned max);
    if (c == 9'd0) return 1;
    if (32'(c) > max) return max;
    return 32'(c);
  endfunction

  function automatic logic signed [31:0] mix_q16(input logic signed [31:0] a, b,
                                                 input int unsigned f);
    longint s;
    s = longint'(a) * (65536 - longint'(f)) + longint'(b) * longint'(f);
    s = (s + 32768) >>> 16;
    return s[31:0];
  endfunction

  function automatic bit axis_find(input logic signed [31:0] coord, origin,
                                   input logic [31:0] inv, input int unsigned cnt,
                                   output int unsigned idx, output int unsigned frac);
    longint     d;
    logic [63:0] p;
    idx  = 0;
    frac = 0;
    d = longint'(coord) - longint'(origin);
    if (d < 0) return 1'b0;
    p = 64'(d) * {32'd0, inv};
    if (p > (64'(cnt - 1) << 32)) return 1'b0;
    idx  = p[63:32];
    frac = 32'(p[31:16]);
    return 1'b1;
  endfunction

  function automatic logic signed [31:0] peek(input int unsigned r, c, inout bit ok);
    if (!grid_set[r * 256 + c]) ok = 1'b0;
    return grid_mem[r * 256 + c];
  endfunction

  function automatic logic signed [31:0] lane_mix(input int unsigned r, c, cnt, fx,
                                                  inout bit ok);
    logic signed [31:0] z0;
    z0 = peek(r, c, ok);
    if (c + 1 < cnt) return mix_q16(z0, peek(r, c + 1, ok), fx);
    return z0;
  endfunction

  // Returns 0 when the lookup would touch a sample never written.
  function automatic bit elevation_at(input logic signed [31:0] east, north,
                                      output logic signed [31:0] elev,
                                      output logic outside);
    int unsigned        ce, cn, ci, ri, fe, fn;
    logic signed [31:0] r0;
    bit                 ok;
    ok = 1'b1;
    ce = live_count(geo_cols, gbe_pkg::MAX_COLUMNS_DEF);
    cn = live_count(geo_rows, gbe_pkg::MAX_ROWS_DEF);
    if (!axis_find(east, geo_origin_e, geo_inv_e, ce, ci, fe) ||
        !axis_find(north, geo_origin_n, geo_inv_n, cn, ri, fn)) begin
      elev    = gbe_pkg::OUTSIDE_VALUE;
      outside = 1'b1;
      return 1'b1;
    end
    outside = 1'b0;
    r0 = lane_mix(ri, ci, ce, fe, ok);
    if (ri + 1 < cn) elev = mix_q16(r0, lane_mix(ri + 1, ci, ce, fe, ok), fn);
    else elev = r0;
    return ok;
  endfunction

  function automatic logic signed [31:0] aim_axis(input logic signed [31:0] origin,
                                                  input logic [31:0] inv,
                                                  input int unsigned cnt);
    int unsigned sel, pick;
    logic [63:0] p_aim;
    longint      spot;
    sel = $urandom_range(0, 99);
    if (sel < 6) return $urandom;
    if (sel < 12) begin
      spot = longint'(origin) - longint'($urandom_range(1, 1 << 18));
    end else begin
      if (cnt <= 8) pick = $urandom_range(0, cnt - 1);
      else if ($urandom_range(0, 1)) pick = $urandom_range(0, 7);
      else pick = cnt - 1 - $urandom_range(0, 7);
      p_aim = 64'(pick) << 32;
      if (sel >= 45) p_aim = p_aim + 64'($urandom);
      if (sel >= 92) p_aim = p_aim + (64'd1 << 32);
      if (inv == 0) spot = longint'(origin) + longint'($urandom_range(0, 1 << 20));
      else spot = longint'(origin) + longint'(p_aim / {32'd0, inv});
    end
    if (spot != longint'(signed'(spot[31:0]))) return $urandom;
    return spot[31:0];
  endfunction

  function automatic logic [31:0] small_origin();
    return 32'($urandom_range(0, 1 << 25)) - 32'(1 << 24);
  endfunction

  function automatic grid_setup_t random_setup();
    grid_setup_t s;
    s.org_e = small_origin();
    s.org_n = small_origin();
    s.inv_e = $urandom_range(32'h2000, 32'h8_0000);
    s.inv_n = $urandom_range(32'h2000, 32'h8_0000);
    s.cols  = 9'($urandom_range(2, 8));
    s.rows  = 9'($urandom_range(2, 8));
    return s;
  endfunction

  function automatic grid_item_t make_write(input logic [7:0] c, r,
                                            input logic signed [31:0] s);
    grid_item_t it;
    it.op        = gbe_pkg::OP_WRITE;
    it.column    = c;
    it.row       = r;
    it.sample    = s;
    it.east      = $urandom;
    it.north     = $urandom;
    it.typed     = 1'b0;
    it.want_elev = '0;
    it.want_out  = 1'b0;
    return it;
  endfunction

  function automatic void note_reg(input logic [2:0] idx, input logic [31:0] val);
    case (idx)
      gbe_pkg::CFG_ORIGIN_EAST:    geo_origin_e = val;
      gbe_pkg::CFG_ORIGIN_NORTH:   geo_origin_n = val;
      gbe_pkg::CFG_INV_CELL_EAST:  geo_inv_e    = val;
      gbe_pkg::CFG_INV_CELL_NORTH: geo_inv_n    = val;
      gbe_pkg::CFG_COLUMNS:        geo_cols     = val[8:0];
      gbe_pkg::CFG_ROWS:           geo_rows     = val[8:0];
      default: ;
    endcase
  endfunction

  task automatic idle_in(input int n);
    in_ch.valid <= 1'b0;
    repeat (n) @(posedge clk);
  endtask

  task automatic pace();
    if (burst_left > 0) begin
      burst_left--;
    end else begin
      idle_in($urandom_range(1, 9));
      burst_left = $urandom_range(0, 30);
    end
  endtask

  task automatic push_item(input grid_item_t it);
    logic signed [31:0] e;
    logic               o;
    in_ch.valid  <= 1'b1;
    in_ch.op     <= it.op;
    in_ch.column <= it.column;
    in_ch.row    <= it.row;
    in_ch.sample <= it.sample;
    in_ch.east   <= it.east;
    in_ch.north  <= it.north;
    @(posedge clk);
    while (!in_ch.ready) @(posedge clk);
    if (it.op == gbe_pkg::OP_WRITE) begin
      grid_mem[{it.row, it.column}] = it.sample;
      grid_set[{it.row, it.column}] = 1'b1;
    end else if (it.typed) begin
      pending_elevs.push_back('{it.want_elev, it.want_out});
    end else begin
      void'(elevation_at(it.east, it.north, e, o));
      pending_elevs.push_back('{e, o});
    end
  endtask

  task automatic hold_for_results();
    idle_in(1);
    while (pending_elevs.size() != 0) @(posedge clk);
  endtask

  task automatic settle();
    hold_for_results();
    repeat (16) @(posedge clk);
  endtask

  task automatic write_reg(input logic [2:0] idx, input logic [31:0] val);
    cfg_ch.valid <= 1'b1;
    cfg_ch.index <= idx;
    cfg_ch.data  <= val;
    @(posedge clk);
    while (!cfg_ch.ready) @(posedge clk);
    note_reg(idx, val);
  endtask

  task automatic program_setup(input grid_setup_t s, input bit spare);
    write_reg(gbe_pkg::CFG_ORIGIN_EAST, s.org_e);
    write_reg(gbe_pkg::CFG_ORIGIN_NORTH, s.org_n);
    write_reg(gbe_pkg::CFG_INV_CELL_EAST, s.inv_e);
    write_reg(gbe_pkg::CFG_INV_CELL_NORTH, s.inv_n);
    write_reg(gbe_pkg::CFG_COLUMNS, {23'($urandom), s.cols});
    write_reg(gbe_pkg::CFG_ROWS, {23'($urandom), s.rows});
    if (spare) write_reg(CFG_SPARE, $urandom);
    cfg_ch.valid <= 1'b0;
  endtask

  task automatic run_phase(input int n);
    grid_item_t         it;
    logic signed [31:0] e, nn, el;
    logic               ou;
    logic [7:0]         c, r;
    bit                 ok;
    int                 tries;
    for (int k = 0; k < n; k++) begin
      if (k == n / 2) hold_for_results();
      if ($urandom_range(0, 99) < 30) begin
        if ($urandom_range(0, 1)) begin
          c = 8'($urandom);
          r = 8'($urandom);
        end else begin
          c = 8'($urandom_range(0, 7)) + ($urandom_range(0, 1) ? 8'd248 : 8'd0);
          r = 8'($urandom_range(0, 7)) + ($urandom_range(0, 1) ? 8'd248 : 8'd0);
        end
        if ($urandom_range(0, 9) == 0)
          it = make_write(c, r, $urandom_range(0, 1) ? 32'h7FFF_FFFF : 32'h8000_0000);
        else
          it = make_write(c, r, $urandom);
      end else begin
        ok = 1'b0;
        for (tries = 0; tries < 10 && !ok; tries++) begin
          e  = aim_axis(geo_origin_e, geo_inv_e,
                        live_count(geo_cols, gbe_pkg::MAX_COLUMNS_DEF));
          nn = aim_axis(geo_origin_n, geo_inv_n,
                        live_count(geo_rows, gbe_pkg::MAX_ROWS_DEF));
          ok = elevation_at(e, nn, el, ou);
        end
        if (!ok) begin
          e  = geo_origin_e;
          nn = geo_origin_n;
        end
        it = make_write(8'($urandom), 8'($urandom), $urandom);
        it.op    = gbe_pkg::OP_QUERY;
        it.east  = e;
        it.north = nn;
      end
      push_item(it);
      pace();
    end
  endtask

  task automatic take_result(input logic signed [31:0] elev, input logic outside);
    elev_answer_t want;
    if (pending_elevs.size() == 0) begin
      err_count++;
      $display("%0t: unexpected result, elevation %h outside %b", $time, elev, outside);
      return;
    end
    want = pending_elevs.pop_front();
    if (elev !== want.elev) begin
      err_count++;
      $display("%0t: elevation expected %h actual %h", $time, want.elev, elev);
    end
    if (outside !== want.outside) begin
      err_count++;
      $display("%0t: outside expected %b actual %b", $time, want.outside, outside);
    end
  endtask

  initial begin : result_side
    int stall_tick;
    int stall_mode;
    stall_tick   = 0;
    stall_mode   = 0;
    out_ch.ready = 1'b0;
    forever begin
      @(posedge clk);
      if (rst_n) begin
        if (out_ch.valid && out_ch.ready) take_result(out_ch.elevation, out_ch.outside);
        stall_tick++;
        if (stall_tick % 64 == 0) stall_mode = $urandom_range(0, 3);
        case (stall_mode)
          0: out_ch.ready <= 1'b1;
          1: out_ch.ready <= ($urandom_range(0, 3) != 0);
          2: out_ch.ready <= (stall_tick % 7 < 2);
          default: out_ch.ready <= (stall_tick % 40 >= 25);
        endcase
      end
    end
  end

  initial begin
    #800000;
    $display("CHECK FAILED");
    $finish;
  end

  initial begin
    grid_setup_t plan [8];
    rst_n        = 1'b0;
    in_ch.valid  = 1'b0;
    in_ch.op     = gbe_pkg::OP_WRITE;
    in_ch.column = '0;
    in_ch.row    = '0;
    in_ch.sample = '0;
    in_ch.east   = '0;
    in_ch.north  = '0;
    cfg_ch.valid = 1'b0;
    cfg_ch.index = gbe_pkg::CFG_ORIGIN_EAST;
    cfg_ch.data  = '0;
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;

    foreach (opening_rows[k]) begin
      push_item(opening_rows[k]);
      pace();
    end

    for (int r = 0; r < 8; r++) begin
      for (int c = 0; c < 8; c++) begin
        push_item(make_write(8'(c), 8'(r), $urandom));
        pace();
        push_item(make_write(8'(248 + c), 8'(248 + r), $urandom));
        pace();
      end
    end

    plan[0] = '{32'h0, 32'h0, 32'h0001_0000, 32'h0001_0000, 9'd4, 9'd3};
    plan[1] = '{32'h8000_0000, 32'h7FFF_FFFF, 32'hFFFF_FFFF, 32'h1, 9'd256, 9'd2};
    plan[2] = '{$urandom, $urandom, $urandom, $urandom, 9'd0, 9'd1};
    plan[3] = '{small_origin(), small_origin(), 32'h0, 32'h0000_8000, 9'd511, 9'd257};
    plan[4] = random_setup();
    plan[5] = random_setup();
    plan[6] = random_setup();
    plan[7] = '{32'h0, 32'h0, 32'h0001_0000, 32'h0001_0000, 9'd256, 9'd256};

    foreach (plan[p]) begin
      settle();
      program_setup(plan[p], p == 2);
      run_phase(45);
    end
    settle();

    if (err_count == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule

// ===== sim.f =====
hdl/gbe_pkg.sv
hdl/gbe_in_if.sv
hdl/gbe_out_if.sv
hdl/gbe_cfg_if.sv
hdl/gbe_ram.sv
hdl/gbe_cfg.sv
hdl/gbe_locate.sv
hdl/gbe_blend.sv
hdl/grid_bilinear_elevation_top.sv
sim/tb_grid_bilinear_elevation_top.sv
